FILE: src/stoi_pkg.sv
// ----------------------------------------------------------------------------
// stoi_pkg
// widths, constants and the search stage record of the swept circle block
// ----------------------------------------------------------------------------
package stoi_pkg;

  localparam int PosW  = 24;  // Q15.8 positions
  localparam int RadW  = 16;  // Q8.8 radii
  localparam int ToiW  = 17;  // Q0.16 time, one more bit for 1.0
  localparam int DifW  = 26;  // relative steps and offsets
  localparam int RrW   = RadW + 1;
  localparam int PrdW  = 2 * DifW;
  localparam int RsqW  = 2 * RrW;
  localparam int QW    = 53;  // quadratic coefficients a, b, c
  localparam int MagW  = 52;  // magnitudes for the discriminant
  localparam int HalfW = MagW / 2;
  localparam int HpW   = 2 * HalfW;
  localparam int SqW   = 2 * MagW;
  localparam int HW    = 72;  // a*t + 65536*b
  localparam int GW    = 92;  // 2^32 * f(t)
  localparam int SrchN = ToiW;
  localparam int DiscStage = 3;

  localparam logic [ToiW-1:0] ToiOne  = ToiW'(65536);
  localparam logic [ToiW-1:0] ToiZero = '0;

  typedef struct packed {
    logic [ToiW-1:0]        t;
    logic signed [GW-1:0]   g;
    logic signed [HW-1:0]   h;
    logic signed [QW-1:0]   qa;
    logic                   first;
    logic                   a_zero;
    logic                   c_le0;
    logic                   sel1;
    logic                   sel2;
    logic                   disc_ok;
  } srch_t;

  function automatic logic signed [DifW-1:0] sx(input logic [PosW-1:0] v);
    sx = {{(DifW-PosW){v[PosW-1]}}, v};
  endfunction

endpackage

FILE: src/stoi_in_if.sv
// ----------------------------------------------------------------------------
// stoi_in_if
// input channel: one circle pair per item
// ----------------------------------------------------------------------------
interface stoi_in_if import stoi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PosW-1:0]       first_now_x;
  logic [PosW-1:0]       first_now_y;
  logic [PosW-1:0]       first_prev_x;
  logic [PosW-1:0]       first_prev_y;
  logic [RadW-1:0]       first_radius;
  logic [PosW-1:0]       second_now_x;
  logic [PosW-1:0]       second_now_y;
  logic [PosW-1:0]       second_prev_x;
  logic [PosW-1:0]       second_prev_y;
  logic [RadW-1:0]       second_radius;

  modport source(output valid, first_now_x, first_now_y, first_prev_x, first_prev_y,
                 first_radius, second_now_x, second_now_y, second_prev_x, second_prev_y,
                 second_radius, input ready);
  modport sink(input valid, first_now_x, first_now_y, first_prev_x, first_prev_y,
               first_radius, second_now_x, second_now_y, second_prev_x, second_prev_y,
               second_radius, output ready);
endinterface

FILE: src/stoi_out_if.sv
// ----------------------------------------------------------------------------
// stoi_out_if
// result channel: contact time and hit flag per item
// ----------------------------------------------------------------------------
interface stoi_out_if import stoi_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ToiW-1:0] time_of_impact;
  logic            hit;

  modport source(output valid, time_of_impact, hit, input ready);
  modport sink(input valid, time_of_impact, hit, output ready);
endinterface

FILE: src/swept_circle_time_of_impact.sv
// ----------------------------------------------------------------------------
// swept_circle_time_of_impact
// swept circle against circle contact time, exact fixed point root search
// ----------------------------------------------------------------------------
// throughput: one item per cycle; a stage holds only while the stage after it
//   is full and stalled, bubbles close up
// the root is found one time bit per stage, 17 stages of shift and add
// reset: rst clears all valid bits, the pipeline comes up empty
module swept_circle_time_of_impact import stoi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  stoi_in_if.sink    pairs,
  stoi_out_if.source impacts
);

  localparam int NS   = 4 + SrchN + 1;  // front, prep, search, output
  localparam int Outs = NS - 1;

  logic [NS-1:0] v;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = impacts.ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign pairs.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= (i == 0) ? pairs.valid : v[i-1];
        end
      end
    end
  end

  // relative step and offset
  logic signed [DifW-1:0] vx, vy, px, py;
  logic [RrW-1:0]         rr;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      vx <= sx(pairs.second_now_x) - sx(pairs.second_prev_x)
          - sx(pairs.first_now_x) + sx(pairs.first_prev_x);
      vy <= sx(pairs.second_now_y) - sx(pairs.second_prev_y)
          - sx(pairs.first_now_y) + sx(pairs.first_prev_y);
      px <= sx(pairs.second_now_x) - sx(pairs.first_now_x);
      py <= sx(pairs.second_now_y) - sx(pairs.first_now_y);
      rr <= RrW'(pairs.first_radius) + RrW'(pairs.second_radius);
    end
  end

  logic signed [PrdW-1:0] pvvx, pvvy, pvpx, pvpy, pppx, pppy;
  logic [RsqW-1:0]        rsq;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pvvx <= vx * vx;
      pvvy <= vy * vy;
      pvpx <= vx * px;
      pvpy <= vy * py;
      pppx <= px * px;
      pppy <= py * py;
      rsq  <= rr * rr;
    end
  end

  logic signed [QW-1:0] qa, qb, qc;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      qa <= QW'(pvvx) + QW'(pvvy);
      qb <= QW'(pvpx) + QW'(pvpy);
      qc <= QW'(pppx) + QW'(pppy) - QW'($signed({1'b0, rsq}));
    end
  end

  // root selection and search start
  srch_t s [0:SrchN];
  logic [MagW-1:0] bmag, amag, cmag;
  logic            c_pos0, c_pos1, c_pos2;

  logic signed [QW+1:0] f1, ab;
  logic                 b_le0, c_ge0, c_le0;
  always_comb begin
    f1    = (QW+2)'(qa) + ((QW+2)'(qb) <<< 1) + (QW+2)'(qc);
    ab    = (QW+2)'(qa) + (QW+2)'(qb);
    b_le0 = qb <= 0;
    c_ge0 = qc >= 0;
    c_le0 = qc <= 0;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s[0].t       <= '0;
      s[0].g       <= GW'(qc) <<< 32;
      s[0].h       <= HW'(qb) <<< 16;
      s[0].qa      <= qa;
      s[0].sel1    <= b_le0 && c_ge0 && (ab >= 0 || f1 <= 0);
      s[0].sel2    <= (b_le0 || c_le0) && ab >= 0 && f1 >= 0;
      s[0].first   <= b_le0 && c_ge0 && (ab >= 0 || f1 <= 0);
      s[0].a_zero  <= qa == 0;
      s[0].c_le0   <= c_le0;
      s[0].disc_ok <= 1'b0;
      bmag   <= qb[QW-1] ? MagW'(-qb) : MagW'(qb);
      amag   <= MagW'(qa);
      cmag   <= MagW'(qc);
      c_pos0 <= !c_le0;
    end
  end

  // discriminant sign: b^2 against a*c from half-width partial products
  logic [HpW-1:0] pbhh, pbhl, pbll, pchh, pchl, pclh, pcll;
  logic [SqW-1:0] bsq, acp;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      pbhh   <= bmag[MagW-1:HalfW] * bmag[MagW-1:HalfW];
      pbhl   <= bmag[MagW-1:HalfW] * bmag[HalfW-1:0];
      pbll   <= bmag[HalfW-1:0] * bmag[HalfW-1:0];
      pchh   <= amag[MagW-1:HalfW] * cmag[MagW-1:HalfW];
      pchl   <= amag[MagW-1:HalfW] * cmag[HalfW-1:0];
      pclh   <= amag[HalfW-1:0] * cmag[MagW-1:HalfW];
      pcll   <= amag[HalfW-1:0] * cmag[HalfW-1:0];
      c_pos1 <= c_pos0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      bsq <= (SqW'(pbhh) << MagW) + (SqW'(pbhl) << (HalfW + 1)) + SqW'(pbll);
      acp <= (SqW'(pchh) << MagW) + ((SqW'(pchl) + SqW'(pclh)) << HalfW) + SqW'(pcll);
      c_pos2 <= c_pos1;
    end
  end

  // one time bit per stage, msb first; f and the vertex test move by shifts
  for (genvar j = 1; j <= SrchN; j++) begin : g_srch
    localparam int B = SrchN - j;
    logic signed [HW-1:0] h_try;
    logic signed [GW-1:0] g_try;
    logic                 ok, take;
    srch_t                s_next;

    always_comb begin
      h_try = s[j-1].h + (HW'(s[j-1].qa) <<< B);
      g_try = s[j-1].g + (GW'(s[j-1].h) <<< (B + 1)) + (GW'(s[j-1].qa) <<< (2 * B));
      if (s[j-1].first) begin
        ok = (h_try <= 0) && !g_try[GW-1];
      end else begin
        ok = (h_try <= 0) || (g_try <= 0);
      end
      take = ok && !s[j-1].t[ToiW-1];
      s_next = s[j-1];
      if (take) begin
        s_next.t = s[j-1].t | (ToiW'(1) << B);
        s_next.h = h_try;
        s_next.g = g_try;
      end
      if (j == DiscStage) begin
        s_next.disc_ok = !c_pos2 || (bsq >= acp);
      end
    end

    always_ff @(posedge clk) begin
      if (en[3+j]) begin
        s[j] <= s_next;
      end
    end
  end

  logic [ToiW-1:0] toi;
  logic            hit;

  always_ff @(posedge clk) begin
    if (en[Outs]) begin
      if (s[SrchN].a_zero) begin
        hit <= s[SrchN].c_le0;
        toi <= s[SrchN].c_le0 ? ToiZero : ToiOne;
      end else if (s[SrchN].disc_ok && (s[SrchN].sel1 || s[SrchN].sel2)) begin
        hit <= 1'b1;
        toi <= s[SrchN].t;
      end else begin
        hit <= 1'b0;
        toi <= ToiOne;
      end
    end
  end

  assign impacts.valid          = v[Outs];
  assign impacts.time_of_impact = toi;
  assign impacts.hit            = hit;

endmodule

FILE: src/stoi_checker.sv
// ----------------------------------------------------------------------------
// stoi_checker
// port level checks on the result channel of the swept circle block
// ----------------------------------------------------------------------------
module stoi_checker import stoi_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            o_valid,
  input logic            o_ready,
  input logic [ToiW-1:0] toi,
  input logic            hit
);

  // a miss always reports the full step
  a_miss: assert property (@(posedge clk) disable iff (rst)
    o_valid && !hit |-> toi == ToiOne)
    else $error("miss without full step time");

  a_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> toi <= ToiOne)
    else $error("time above one step");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_ready |=> o_valid && $stable(toi) && $stable(hit))
    else $error("stalled item changed");

  a_empty: assert property (@(posedge clk)
    rst |=> !o_valid)
    else $error("item out of reset");

endmodule

bind swept_circle_time_of_impact stoi_checker u_stoi_checker (
  .clk     (clk),
  .rst     (rst),
  .o_valid (impacts.valid),
  .o_ready (impacts.ready),
  .toi     (impacts.time_of_impact),
  .hit     (impacts.hit)
);
